// File: src/ctcgd_pkg.sv
// Package for the CTC greedy decoder: word types, sequencer states, exp table.
// No dependencies.
`default_nettype none
package ctcgd_pkg;

  typedef struct packed {
    logic signed [15:0] logit;
    logic               step_end;
    logic               sequence_end;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [14:0] symbol_index;
    logic [15:0] probability;
    logic [8:0]  symbol_count;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SDIV, ST_SYM, ST_MDIV, ST_SUM
  } state_e;

  localparam int unsigned ExpIndexShift = 4;
  localparam logic [15:0] ExpOne = 16'hFFFF;
  localparam logic [31:0] ExpRatio = 32'd61565;

  localparam logic       KindSymbol  = 1'b0;
  localparam logic       KindSummary = 1'b1;

  // Next table entry from the current one: round(v * ratio / 2^16).
  function automatic logic [15:0] exp_next(input logic [15:0] v);
    logic [47:0] p;
    p = {32'd0, v} * {16'd0, ExpRatio} + 48'd32768;
    return p[31:16];
  endfunction

endpackage
`default_nettype wire

// File: src/ctc_greedy_decoder_unit.sv
// CTC greedy decoder top level: argmax, online softmax sum, symbol emit.
// Depends on ctcgd_pkg, ctcgd_exp_rom and ctcgd_divider.
`default_nettype none
// Takes one logit word per cycle within a time step while idle and the
// output register is free; a word that is not a new maximum updates the
// argmax and softmax sum directly, a new maximum passes through ST_MUL and
// ST_SUM for its rescale multiply in the 32x16 multiplier. At a step end the
// block stalls while the shared 32-step serial divider forms the symbol
// probability: ready again after ST_SUM, ST_SDIV and ST_SYM, and a symbol
// word waiting in the output register holds it in ST_SYM. At a sequence end
// a second pass of the divider forms the mean confidence, run again when the
// symbol word is still waiting at the end of the first pass. Results leave
// through a one-word output register; the next logit is taken once it is free.
module ctc_greedy_decoder_unit
  import ctcgd_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS    = 32768,
  parameter int unsigned MAX_STEPS       = 256,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);

  localparam int unsigned CountCap = (MAX_STEPS < 256) ? MAX_STEPS : 256;
  localparam logic [14:0] ChanLast = 15'(MAX_CHANNELS - 1);

  state_e state_q, state_d;
  logic [14:0] pos_q, pos_d, maxch_q, maxch_d, prev_q, prev_d;
  logic signed [15:0] rmax_q, rmax_d;
  logic [31:0] sum_q, sum_d;
  logic [24:0] tot_q, tot_d;
  logic [8:0]  cnt_q, cnt_d;
  logic        seq_q, seq_d;
  logic        resc_q, resc_d;
  logic [15:0] e_q, e_d, prob_q, prob_d;
  logic [47:0] prod_q;
  logic        ov_q, ov_d;
  out_word_t   ob_q, ob_d;

  logic        acc;
  logic signed [16:0] diff;
  logic [16:0] diff_mag;
  logic [15:0] e_lk;
  logic [32:0] add_s;
  logic [31:0] rnd;
  logic [32:0] rnd_s;
  logic        dv_start, dv_done;
  logic [31:0] dv_num, dv_den, dv_quo;

  ctcgd_exp_rom #(.Depth(EXP_TABLE_DEPTH)) u_rom (.diff_i(diff_mag), .exp_o(e_lk));

  ctcgd_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .dividend_i(dv_num),
    .divisor_i(dv_den), .done_o(dv_done), .quotient_o(dv_quo)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && !ov_q;
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;

  // Difference between logit and running maximum, and its magnitude
  assign diff     = 17'(in_data_i.logit) - 17'(rmax_q);
  assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
  assign add_s    = {1'b0, sum_q} + {17'd0, e_lk};
  assign rnd      = 32'((prod_q + 48'd32768) >> 16);
  assign rnd_s    = {1'b0, rnd} + {17'd0, ExpOne};

  // Sequencer
  always_comb begin
    state_d = state_q;
    pos_d = pos_q; maxch_d = maxch_q; prev_d = prev_q; rmax_d = rmax_q;
    sum_d = sum_q; tot_d = tot_q; cnt_d = cnt_q; seq_d = seq_q;
    resc_d = resc_q;
    e_d = e_q; prob_d = prob_q; ov_d = ov_q; ob_d = ob_q;
    dv_start = 1'b0;
    dv_num = {ExpOne, 16'd0};
    dv_den = sum_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          seq_d = in_data_i.sequence_end;
          if (pos_q == '0) begin
            rmax_d = in_data_i.logit; maxch_d = '0; sum_d = {16'd0, ExpOne};
          end else if (!diff[16] && diff != '0) begin
            e_d = e_lk; rmax_d = in_data_i.logit; maxch_d = pos_q;
            resc_d = 1'b1;
            state_d = ST_MUL;
          end else begin
            sum_d = add_s[32] ? '1 : add_s[31:0];
          end
          if (in_data_i.step_end || in_data_i.sequence_end) begin
            pos_d = '0;
            if (state_d == ST_IDLE) state_d = ST_SUM;
          end else if (pos_q < ChanLast) begin
            pos_d = pos_q + 15'd1;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        // Finish the rescale if one was started, then decide on step end
        if (resc_q) begin
          sum_d = rnd_s[32] ? '1 : rnd_s[31:0];
        end
        resc_d = 1'b0;
        e_d = '0;
        state_d = (pos_q == '0) ? ST_SDIV : ST_IDLE;
        if (pos_q == '0) dv_start = 1'b1;
        if (pos_q == '0) dv_den = resc_q ? (rnd_s[32] ? '1 : rnd_s[31:0]) : sum_q;
      end
      ST_SDIV: begin
        if (dv_done) begin
          prob_d = (sum_q == '0 || dv_quo > 32'd65535) ? 16'hFFFF : dv_quo[15:0];
          state_d = ST_SYM;
        end
      end
      ST_SYM: begin
        if (!ov_q || out_ready_i) begin
          if (maxch_q != '0 && maxch_q != prev_q) begin
            ov_d = 1'b1;
            ob_d.result_kind  = KindSymbol;
            ob_d.symbol_index = maxch_q - 15'd1;
            ob_d.probability  = prob_q;
            ob_d.last         = !seq_q;
            ob_d.symbol_count = cnt_q;
            if (cnt_q < 9'(CountCap)) begin
              tot_d = tot_q + 25'(prob_q);
              cnt_d = cnt_q + 9'd1;
              ob_d.symbol_count = cnt_q + 9'd1;
            end
          end
          prev_d = maxch_q;
          rmax_d = 16'sh8000; maxch_d = '0; sum_d = '0;
          if (seq_q) begin
            dv_start = 1'b1;
            dv_num = {7'd0, tot_d};
            dv_den = {23'd0, cnt_d};
            state_d = ST_MDIV;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MDIV: begin
        if (dv_done && !ov_q) begin
          ov_d = 1'b1;
          ob_d.result_kind  = KindSummary;
          ob_d.symbol_index = '0;
          ob_d.probability  = (cnt_q == '0) ? 16'd0 :
                              ((dv_quo > 32'd65535) ? 16'hFFFF : dv_quo[15:0]);
          ob_d.symbol_count = cnt_q;
          ob_d.last         = 1'b1;
          prev_d = '0; tot_d = '0; cnt_d = '0;
          state_d = ST_IDLE;
        end else if (dv_done) begin
          state_d = ST_MDIV;
          dv_start = 1'b1;
          dv_num = {7'd0, tot_q};
          dv_den = {23'd0, cnt_q};
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q <= '0; maxch_q <= '0; prev_q <= '0; rmax_q <= 16'sh8000;
      sum_q <= '0; tot_q <= '0; cnt_q <= '0; seq_q <= 1'b0;
      resc_q <= 1'b0;
      e_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d; maxch_q <= maxch_d; prev_q <= prev_d; rmax_q <= rmax_d;
      sum_q <= sum_d; tot_q <= tot_d; cnt_q <= cnt_d; seq_q <= seq_d;
      resc_q <= resc_d;
      e_q <= e_d; ov_q <= ov_d;
    end
  end

  // Payload registers; multiplier product registered from sum and table value
  always_ff @(posedge clk_i) begin
    prob_q <= prob_d;
    ob_q   <= ob_d;
    prod_q <= (state_q == ST_MUL) ? (sum_q * e_q) : 48'd0;
  end

endmodule
`default_nettype wire

// File: src/ctcgd_divider.sv
// Shared restoring divider, one quotient bit per cycle, 32-bit operands.
// Does not depend on ctcgd_pkg; uses none of its types.
`default_nettype none
module ctcgd_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quotient_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  // One shift-subtract step per cycle while busy
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, div_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// File: src/ctcgd_exp_rom.sv
// Exponential table: entry k is about 65536*exp(-k/16), built at elaboration.
// Depends on ctcgd_pkg for exp_next.
`default_nettype none
module ctcgd_exp_rom
  import ctcgd_pkg::*;
#(
  parameter int unsigned Depth = 256
) (
  input  wire logic [16:0] diff_i,
  output logic [15:0]      exp_o
);

  localparam int unsigned IdxW = $clog2(Depth);

  logic [15:0] rom [Depth];
  logic [16:0] idx_full;

  // Constant recurrence, folded by synthesis
  always_comb begin
    rom[0] = ExpOne;
    for (int k = 1; k < Depth; k++) begin
      rom[k] = exp_next(rom[k-1]);
    end
  end

  assign idx_full = diff_i >> ExpIndexShift;
  assign exp_o = (idx_full >= 17'(Depth)) ? 16'd0 : rom[idx_full[IdxW-1:0]];

endmodule
`default_nettype wire
